// File: sv/lps_pkg.sv
// Shared types and codes for the LED pattern sequencer.
`default_nettype none
package lps_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned LED_W   = 8;
   localparam int unsigned PHASE_W = 5;
   localparam int unsigned AMODE_W = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [AMODE_W-1:0] MODE_IDLE = 4'd8;

   localparam logic [TICK_W-1:0] FLASH_TICKS_RST = 16'd250;
   localparam logic [TICK_W-1:0] BLINK_TICKS_RST = 16'd125;
   localparam logic [TICK_W-1:0] FILL_TICKS_RST  = 16'd150;

   typedef enum logic [2:0] {
      PAT_FLASH     = 3'd0,
      PAT_STEP_UP   = 3'd1,
      PAT_STEP_DOWN = 3'd2,
      PAT_CONVERGE  = 3'd3,
      PAT_DIVERGE   = 3'd4,
      PAT_UP_DOWN   = 3'd5,
      PAT_SNAKE     = 3'd6,
      PAT_CONV_DIV  = 3'd7
   } pattern_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLASH_TICKS = 2'd0,
      CSR_BLINK_TICKS = 2'd1,
      CSR_FILL_TICKS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TICK_W-1:0] flash_ticks;
      logic [TICK_W-1:0] blink_ticks;
      logic [TICK_W-1:0] fill_ticks;
   } cfg_type;

   typedef struct packed {
      logic               busy;
      pattern_type        mode;
      logic [PHASE_W-1:0] phase;
      logic [TICK_W-1:0]  remaining;
   } seq_state_type;

   typedef struct packed {
      logic [LED_W-1:0]   leds;
      logic [AMODE_W-1:0] active_mode;
      logic               pattern_done;
   } result_type;

endpackage
`default_nettype wire

// File: sv/lps_step.sv
// Combinational next-state and LED output logic for one tick of the sequencer.
`default_nettype none
module lps_step (
   input  wire lps_pkg::seq_state_type state,
   input  wire lps_pkg::cfg_type       cfg,
   input  wire logic [7:0]             switches,
   output lps_pkg::seq_state_type      state_in,
   output lps_pkg::result_type         result
);
   import lps_pkg::*;

   function automatic logic [LED_W-1:0] step_up(input logic [PHASE_W-1:0] p);
      return p[0] ? 8'h00 : (8'h01 << p[3:1]);
   endfunction

   function automatic logic [LED_W-1:0] step_down(input logic [PHASE_W-1:0] p);
      return p[0] ? 8'h00 : (8'h80 >> p[3:1]);
   endfunction

   function automatic logic [LED_W-1:0] converge(input logic [PHASE_W-1:0] p);
      logic [LED_W-1:0] v;
      case (p[2:0])
         3'd0: v = 8'h00;
         3'd1, 3'd2: v = 8'h81;
         3'd3, 3'd4: v = 8'hC3;
         3'd5, 3'd6: v = 8'hE7;
         default: v = 8'hFF;
      endcase
      return v;
   endfunction

   function automatic logic [LED_W-1:0] diverge(input logic [PHASE_W-1:0] p);
      logic [LED_W-1:0] v;
      case (p[2:0])
         3'd0: v = 8'h00;
         3'd1, 3'd2: v = 8'h18;
         3'd3, 3'd4: v = 8'h3C;
         3'd5, 3'd6: v = 8'h7E;
         default: v = 8'hFF;
      endcase
      return v;
   endfunction

   function automatic logic [LED_W-1:0] phase_leds(input pattern_type m,
                                                  input logic [PHASE_W-1:0] p);
      logic [LED_W-1:0] v;
      case (m)
         PAT_FLASH:     v = p[0] ? 8'h00 : 8'hFF;
         PAT_STEP_UP:   v = step_up(p);
         PAT_STEP_DOWN: v = step_down(p);
         PAT_CONVERGE:  v = converge(p);
         PAT_DIVERGE:   v = diverge(p);
         PAT_UP_DOWN:   v = p[4] ? step_down(p) : step_up(p);
         PAT_SNAKE:     v = p[3] ? (8'hFF << (3'd7 - p[2:0]))
                                 : (8'hFF >> (3'd7 - p[2:0]));
         PAT_CONV_DIV:  v = p[3] ? diverge(p) : converge(p);
         default:       v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [PHASE_W:0] phase_count(input pattern_type m);
      logic [PHASE_W:0] c;
      case (m)
         PAT_FLASH:                        c = 6'd2;
         PAT_STEP_UP, PAT_STEP_DOWN:       c = 6'd16;
         PAT_CONVERGE, PAT_DIVERGE:        c = 6'd8;
         PAT_UP_DOWN:                      c = 6'd32;
         default:                          c = 6'd16;
      endcase
      return c;
   endfunction

   function automatic logic [TICK_W-1:0] phase_ticks(input pattern_type m,
                                                    input cfg_type c);
      logic [TICK_W-1:0] t;
      case (m)
         PAT_FLASH:                             t = c.flash_ticks;
         PAT_STEP_UP, PAT_STEP_DOWN, PAT_UP_DOWN: t = c.blink_ticks;
         default:                               t = c.fill_ticks;
      endcase
      return (t == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : t;
   endfunction

   pattern_type        cur_mode;
   logic [PHASE_W-1:0] cur_phase;
   logic [TICK_W-1:0]  cur_rem;
   logic [TICK_W-1:0]  mode_ticks;
   logic               last_phase;

   always_comb begin
      cur_mode   = state.busy ? state.mode : pattern_type'(switches[2:0]);
      mode_ticks = phase_ticks(cur_mode, cfg);
      cur_phase  = state.busy ? state.phase : '0;
      cur_rem    = state.busy ? state.remaining : mode_ticks;
      last_phase = ({1'b0, cur_phase} + 6'd1) >= phase_count(cur_mode);

      state_in = state;
      result.leds         = phase_leds(cur_mode, cur_phase);
      result.active_mode  = {1'b0, cur_mode};
      result.pattern_done = 1'b0;

      if (!state.busy && (switches[7:3] != 5'd0)) begin
         result.leds        = '0;
         result.active_mode = MODE_IDLE;
      end else begin
         state_in.busy = 1'b1;
         state_in.mode = cur_mode;
         if (cur_rem <= 16'd1) begin
            if (last_phase) begin
               result.pattern_done = 1'b1;
               state_in.busy       = 1'b0;
               state_in.phase      = '0;
               state_in.remaining  = '0;
            end else begin
               state_in.phase     = cur_phase + 5'd1;
               state_in.remaining = mode_ticks;
            end
         end else begin
            state_in.phase     = cur_phase;
            state_in.remaining = cur_rem - 16'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: sv/led_pattern_sequencer.sv
// Top level of the LED pattern sequencer: registers, output stage and skid buffer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_switches
//   rsp      out        rsp_valid/rsp_stall  rsp_leds, rsp_active_mode, rsp_pattern_done
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// Each accepted request gives one response; the per-tick step logic is one short pass.
// A request can be accepted in every cycle while the skid register is empty.
// A skid register holds one response while rsp_stall is high, and req_stall rises only
// when both the output and skid registers are full.
// Reset returns the sequencer to idle and loads the default tick counts.
`default_nettype none
module led_pattern_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_switches,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lps_pkg::LED_W-1:0]        rsp_leds,
   output logic [lps_pkg::AMODE_W-1:0]      rsp_active_mode,
   output logic                             rsp_pattern_done,
   input  wire logic                        csr_write_en,
   input  wire logic [lps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lps_pkg::TICK_W-1:0]  csr_wdata
);
   import lps_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   seq_state_type state_ff, state_in;
   result_type    step_result;
   result_type    out_ff, out_in;
   result_type    skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   logic          accept;
   logic          out_free;

   lps_step u_step (
      .state    (state_ff),
      .cfg      (cfg_ff),
      .switches (req_switches),
      .state_in (state_in),
      .result   (step_result)
   );

   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FLASH_TICKS: cfg_in.flash_ticks = csr_wdata;
            CSR_BLINK_TICKS: cfg_in.blink_ticks = csr_wdata;
            CSR_FILL_TICKS:  cfg_in.fill_ticks  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || accept;
         out_in        = skid_valid_ff ? skid_ff : step_result;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_ticks <= FLASH_TICKS_RST;
         cfg_ff.blink_ticks <= BLINK_TICKS_RST;
         cfg_ff.fill_ticks  <= FILL_TICKS_RST;
         state_ff.busy      <= 1'b0;
         state_ff.mode      <= PAT_FLASH;
         state_ff.phase     <= '0;
         state_ff.remaining <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_leds         = out_ff.leds;
   assign rsp_active_mode  = out_ff.active_mode;
   assign rsp_pattern_done = out_ff.pattern_done;

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the LED pattern sequencer with a tick-level scoreboard.
`timescale 1ns / 100ps
module tb;
   import lps_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int HOLD_OFF_AFTER = 700;
   localparam int RANDOM_ROUNDS = 6;
   localparam int TICKS_PER_ROUND = 120;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   class led_tick_scoreboard;
      cfg_type cfg;
      seq_state_type st;
      result_type led_results_due[$];
      int fault_count;

      function new();
         cfg.flash_ticks = FLASH_TICKS_RST;
         cfg.blink_ticks = BLINK_TICKS_RST;
         cfg.fill_ticks = FILL_TICKS_RST;
         st.busy = 1'b0;
         st.mode = PAT_FLASH;
         st.phase = '0;
         st.remaining = '0;
         fault_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
         case (idx)
            CSR_FLASH_TICKS: cfg.flash_ticks = val;
            CSR_BLINK_TICKS: cfg.blink_ticks = val;
            CSR_FILL_TICKS: cfg.fill_ticks = val;
            default: ;
         endcase
      endfunction

      function logic [TICK_W-1:0] ticks_for(pattern_type m);
         logic [TICK_W-1:0] t;
         case (m)
            PAT_FLASH: t = cfg.flash_ticks;
            PAT_STEP_UP, PAT_STEP_DOWN, PAT_UP_DOWN: t = cfg.blink_ticks;
            default: t = cfg.fill_ticks;
         endcase
         return (t == '0) ? TICK_W'(1) : t;
      endfunction

      function int phase_total(pattern_type m);
         case (m)
            PAT_FLASH: return 2;
            PAT_CONVERGE, PAT_DIVERGE: return 8;
            PAT_UP_DOWN: return 32;
            default: return 16;
         endcase
      endfunction

      function logic [LED_W-1:0] single_up(logic [PHASE_W-1:0] p);
         return p[0] ? 8'h00 : (8'h01 << p[3:1]);
      endfunction

      function logic [LED_W-1:0] single_down(logic [PHASE_W-1:0] p);
         return p[0] ? 8'h00 : (8'h80 >> p[3:1]);
      endfunction

      function logic [LED_W-1:0] converge_mask(logic [2:0] q);
         logic [LED_W-1:0] v;
         int pairs;
         v = '0;
         pairs = (int'(q) + 1) / 2;
         for (int i = 0; i < pairs; i++) begin
            v[i] = 1'b1;
            v[7-i] = 1'b1;
         end
         return v;
      endfunction

      function logic [LED_W-1:0] diverge_mask(logic [2:0] q);
         logic [LED_W-1:0] v;
         int pairs;
         v = '0;
         pairs = (int'(q) + 1) / 2;
         for (int i = 0; i < pairs; i++) begin
            v[3-i] = 1'b1;
            v[4+i] = 1'b1;
         end
         return v;
      endfunction

      function logic [LED_W-1:0] phase_leds(pattern_type m, logic [PHASE_W-1:0] p);
         case (m)
            PAT_FLASH: return p[0] ? 8'h00 : 8'hFF;
            PAT_STEP_UP: return single_up(p);
            PAT_STEP_DOWN: return single_down(p);
            PAT_CONVERGE: return converge_mask(p[2:0]);
            PAT_DIVERGE: return diverge_mask(p[2:0]);
            PAT_UP_DOWN: return p[4] ? single_down(p) : single_up(p);
            PAT_SNAKE: return p[3] ? (8'hFF << (3'd7 - p[2:0]))
                                   : LED_W'((9'd2 << p[2:0]) - 9'd1);
            default: return p[3] ? diverge_mask(p[2:0]) : converge_mask(p[2:0]);
         endcase
      endfunction

      function result_type advance_tick(logic [7:0] sw);
         result_type r;
         r.leds = '0;
         r.active_mode = MODE_IDLE;
         r.pattern_done = 1'b0;
         if (!st.busy) begin
            if (sw > 8'd7) begin
               return r;
            end
            st.busy = 1'b1;
            st.mode = pattern_type'(sw[2:0]);
            st.phase = '0;
            st.remaining = ticks_for(st.mode);
         end
         r.leds = phase_leds(st.mode, st.phase);
         r.active_mode = {1'b0, st.mode};
         if (st.remaining <= 1) begin
            if (int'(st.phase) + 1 >= phase_total(st.mode)) begin
               r.pattern_done = 1'b1;
               st.busy = 1'b0;
               st.phase = '0;
               st.remaining = '0;
            end else begin
               st.phase = st.phase + 1'b1;
               st.remaining = ticks_for(st.mode);
            end
         end else begin
            st.remaining = st.remaining - 1'b1;
         end
         return r;
      endfunction

      function void note_request(logic [7:0] sw);
         led_results_due.push_back(advance_tick(sw));
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (led_results_due.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected result leds %h mode %0d done %0b", $time,
                        got.leds, got.active_mode, got.pattern_done);
            return;
         end
         want = led_results_due.pop_front();
         if (got.leds !== want.leds || got.active_mode !== want.active_mode ||
             got.pattern_done !== want.pattern_done) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: expected leds %h mode %0d done %0b, got leds %h mode %0d done %0b",
                        $time, want.leds, want.active_mode, want.pattern_done,
                        got.leds, got.active_mode, got.pattern_done);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_switches;
   logic rsp_valid;
   logic rsp_stall;
   logic [LED_W-1:0] rsp_leds;
   logic [AMODE_W-1:0] rsp_active_mode;
   logic rsp_pattern_done;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0] csr_wdata;

   led_tick_scoreboard sb = new();
   int burst_left = 0;
   int results_seen = 0;

   led_pattern_sequencer u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_switches(req_switches),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_leds(rsp_leds),
      .rsp_active_mode(rsp_active_mode),
      .rsp_pattern_done(rsp_pattern_done),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_switches);
         if (rsp_valid && !rsp_stall) begin
            sb.check_result({rsp_leds, rsp_active_mode, rsp_pattern_done});
            results_seen++;
         end
      end
   end

   task automatic send_request(input logic [7:0] sw);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_switches <= sw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_switches();
      if (sb.st.busy)
         return 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85)
         return 8'($urandom_range(0, 7));
      return 8'($urandom_range(8, 255));
   endfunction

   function automatic logic [TICK_W-1:0] pick_ticks();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12)
         return '0;
      if (roll < 75)
         return TICK_W'($urandom_range(1, 3));
      return TICK_W'($urandom_range(4, 16));
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.led_results_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic run_to_pattern_end();
      while (sb.st.busy) send_request(pick_switches());
   endtask

   // The first phase runs at the reset length; the register is rewritten just before it ends.
   task automatic check_reset_length(input pattern_type pat, input logic [CSR_IDX_W-1:0] idx,
                                     input int rst_len);
      send_request(8'(pat));
      repeat (rst_len - 2) send_request(pick_switches());
      settle();
      write_reg(idx, TICK_W'(1));
      run_to_pattern_end();
   endtask

   initial begin : stimulus
      int round;
      reset = 1'b1;
      req_valid = 1'b0;
      req_switches = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(8'hFF);
      send_request(8'd8);
      send_request(8'hA5);
      check_reset_length(PAT_FLASH, CSR_FLASH_TICKS, int'(FLASH_TICKS_RST));
      check_reset_length(PAT_STEP_UP, CSR_BLINK_TICKS, int'(BLINK_TICKS_RST));
      check_reset_length(PAT_CONVERGE, CSR_FILL_TICKS, int'(FILL_TICKS_RST));
      settle();
      write_reg(CSR_FLASH_TICKS, TICK_W'(1));
      for (round = 0; round < 8; round++) begin
         send_request(8'(round));
         run_to_pattern_end();
      end
      send_request(8'd8);
      settle();
      write_reg(CSR_FLASH_TICKS, '0);
      write_reg(CSR_BLINK_TICKS, '0);
      write_reg(CSR_FILL_TICKS, '0);
      write_reg(CSR_UNUSED_IDX, 16'h0005);
      send_request(8'(PAT_FLASH));
      run_to_pattern_end();
      send_request(8'(PAT_UP_DOWN));
      run_to_pattern_end();
      send_request(8'(PAT_CONV_DIV));
      run_to_pattern_end();

      for (round = 0; round < RANDOM_ROUNDS; round++) begin
         settle();
         write_reg(CSR_FLASH_TICKS, pick_ticks());
         write_reg(CSR_BLINK_TICKS, pick_ticks());
         write_reg(CSR_FILL_TICKS, pick_ticks());
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_UNUSED_IDX, TICK_W'($urandom_range(0, 65535)));
         repeat (TICKS_PER_ROUND) send_request(pick_switches());
      end

      // Longest phase lengths go last, since a loaded countdown cannot be shortened.
      settle();
      write_reg(CSR_FLASH_TICKS, 16'hFFFF);
      write_reg(CSR_BLINK_TICKS, 16'hFFFF);
      write_reg(CSR_FILL_TICKS, 16'hFFFF);
      repeat (40) send_request(pick_switches());

      settle();
      repeat (8) @(negedge clock);
      if (sb.fault_count == 0 && sb.led_results_due.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin : rsp_side
      int stall_pct;
      int seg_len;
      bit held_off;
      held_off = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         seg_len = $urandom_range(5, 60);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         repeat (seg_len) begin
            if (!held_off && results_seen >= HOLD_OFF_AFTER && req_valid) begin
               held_off = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no request or result accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("tb failed");
      $finish;
   end

endmodule
